// File: design/cqs_pkg.sv
// Shared constants, command and status codes, and controller/datapath
// interface structs for the circular queue with search. No dependencies.
`default_nettype none

package cqs_pkg;

   localparam int DEPTH_DEF  = 16;
   localparam int DATA_W     = 32;
   localparam int CAPACITY_W = 5;
   localparam int FOUND_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 48;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                latch_req;
      logic                write_tail;
      logic                read_head;
      logic                pop;
      logic                scan_start;
      logic                scan_next;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                found_hit;
      logic                load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             full;
      logic             empty;
      logic             match;
      logic             last;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: design/cqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/cqs_ctrl.sv
// Controller state machine for the circular queue: sequences insert,
// remove and search. Depends on cqs_pkg.
`default_nettype none

module cqs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire cqs_pkg::dp_stat_type stat,
   output cqs_pkg::ctrl_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status_code = cqs_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            state_in       = S_DONE;
            unique case (stat.command)
               cqs_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.status_code = cqs_pkg::ST_FULL;
                  end else begin
                     cmd.write_tail = 1'b1;
                  end
               end
               cqs_pkg::CMD_REMOVE: begin
                  if (stat.empty) begin
                     cmd.status_code = cqs_pkg::ST_EMPTY;
                  end else begin
                     cmd.read_head = 1'b1;
                     state_in      = S_RDWAIT;
                  end
               end
               cqs_pkg::CMD_SEARCH: begin
                  if (stat.empty) begin
                     cmd.status_code = cqs_pkg::ST_EMPTY;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  // Unused command code: a no-op that still reports.
                  cmd.status_code = cqs_pkg::ST_OK;
               end
            endcase
         end
         S_RDWAIT: begin
            cmd.pop  = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            priority if (stat.match) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = cqs_pkg::ST_OK;
               cmd.found_hit   = 1'b1;
               state_in        = S_DONE;
            end else if (stat.last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = cqs_pkg::ST_NOTFOUND;
               state_in        = S_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/cqs_datapath.sv
// Datapath of the circular queue: ring pointers, count, capacity register,
// storage RAM, search walker and result register. Depends on cqs_pkg, cqs_ram.
`default_nettype none

module cqs_datapath #(
   parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cqs_pkg::CAPACITY_W-1:0]     csr_wr_data,
   input  wire logic [cqs_pkg::DATA_W-1:0]         req_tdata,
   input  wire logic [cqs_pkg::CMD_W-1:0]          req_tuser,
   input  wire cqs_pkg::ctrl_cmd_type              cmd,
   output cqs_pkg::dp_stat_type                    stat,
   output logic      [cqs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic      [cqs_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CAPW = (CW > cqs_pkg::CAPACITY_W) ? CW : cqs_pkg::CAPACITY_W;
   localparam int PADW = cqs_pkg::RSP_DATA_W - cqs_pkg::DATA_W - cqs_pkg::FOUND_W
                         - cqs_pkg::COUNT_W - 2;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                              input logic [CAPW-1:0] cap);
      logic [CAPW-1:0] inc;
      inc = CAPW'(i) + CAPW'(1);
      return (inc >= cap) ? '0 : AW'(inc);
   endfunction

   logic [cqs_pkg::CAPACITY_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]                  head_ff, head_in;
   logic [AW-1:0]                  tail_ff, tail_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [cqs_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic signed [cqs_pkg::DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic [CW-1:0]                  k_ff, k_in;
   logic [cqs_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic signed [cqs_pkg::DATA_W-1:0] removed_ff, removed_in;
   logic [AW-1:0]                  found_ff, found_in;
   logic [cqs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [cqs_pkg::STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   logic [CAPW-1:0]                cap_ext;
   logic [CAPW-1:0]                cap_use;
   logic [CAPW-1:0]                count_ext;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [cqs_pkg::DATA_W-1:0]     ram_rd_data;

   // Capacity in use: zero acts as one, values beyond the ring act as DEPTH.
   always_comb begin
      cap_ext = CAPW'(cap_ff);
      priority if (cap_ext == '0) begin
         cap_use = CAPW'(1);
      end else if (cap_ext > CAPW'(DEPTH)) begin
         cap_use = CAPW'(DEPTH);
      end else begin
         cap_use = cap_ext;
      end
   end

   assign count_ext = CAPW'(count_ff);

   assign stat.command = cmd_ff;
   assign stat.full    = (count_ext >= cap_use);
   assign stat.empty   = (count_ff == '0);
   assign stat.match   = (ram_rd_data == val_ff);
   assign stat.last    = ((CAPW'(k_ff) + CAPW'(1)) == count_ext);

   // The read for the next search entry is issued while the current one is compared.
   assign ram_rd_en   = cmd.read_head || cmd.scan_start || cmd.scan_next;
   assign ram_rd_addr = cmd.scan_next ? next_idx(pos_ff, cap_use) : head_ff;

   cqs_ram #(
      .WIDTH (cqs_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_storage (
      .clock   (clock),
      .wr_en   (cmd.write_tail),
      .wr_addr (tail_ff),
      .wr_data (val_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      cap_in   = cap_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.write_tail) begin
            tail_in  = next_idx(tail_ff, cap_use);
            count_in = count_ff + CW'(1);
         end
         if (cmd.pop) begin
            head_in  = next_idx(head_ff, cap_use);
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      found_in    = found_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (cmd.latch_req) begin
         cmd_in     = req_tuser;
         val_in     = req_tdata;
         status_in  = cqs_pkg::ST_OK;
         removed_in = '0;
         found_in   = '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.found_hit) begin
         found_in = pos_ff;
      end
      if (cmd.pop) begin
         removed_in = ram_rd_data;
      end
      if (cmd.scan_start) begin
         pos_in = head_ff;
         k_in   = '0;
      end else if (cmd.scan_next) begin
         pos_in = next_idx(pos_ff, cap_use);
         k_in   = k_ff + CW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_data_in = {{PADW{1'b0}},
                        (count_ext == cap_use),
                        (count_ff == '0),
                        cqs_pkg::COUNT_W'(count_ff),
                        cqs_pkg::FOUND_W'(found_ff),
                        removed_ff};
         rsp_user_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cqs_pkg::CAPACITY_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire

// File: design/circular_queue_with_search.sv
// A request passes through the states EXEC and DONE, and the response is registered from DONE;
// remove adds RDWAIT, and search adds SCAN, in which it compares n (1..count) entries from the
// head (none on an empty queue); the search reads one entry per cycle through one RAM read port.
// DONE waits while an earlier result is unread. One command is in flight at a time,
// and the next request is taken the cycle after the previous result enters the output
// register, even while that result is unread. Reset empties the queue, capacity is 16.
`default_nettype none

module circular_queue_with_search #(
   parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cqs_pkg::CAPACITY_W-1:0]     csr_wr_data, // capacity
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [cqs_pkg::DATA_W-1:0]         req_tdata,   // data_value
   input  wire logic [cqs_pkg::CMD_W-1:0]          req_tuser,   // command
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // removed_value[31:0], found_index[35:32], entry_count[40:36],
   // is_empty[41], is_full[42], zero[47:43]
   output logic      [cqs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic      [cqs_pkg::STATUS_W-1:0]       rsp_tuser    // status
);

   cqs_pkg::ctrl_cmd_type cmd;
   cqs_pkg::dp_stat_type  stat;

   cqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cqs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_queue_with_search: random and directed queue
// commands, a built-in queue predictor, and random stalls on both streams. Needs cqs_pkg.

module tb;

   localparam logic [cqs_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 206;

   typedef struct packed {
      logic [cqs_pkg::CMD_W-1:0]  op;
      logic [cqs_pkg::DATA_W-1:0] value;
   } queue_cmd_type;

   typedef struct packed {
      logic [cqs_pkg::STATUS_W-1:0] status;
      logic [cqs_pkg::DATA_W-1:0]   removed;
      logic [cqs_pkg::FOUND_W-1:0]  found;
      logic [cqs_pkg::COUNT_W-1:0]  count;
      logic                         empty;
      logic                         full;
   } queue_reply_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [cqs_pkg::CAPACITY_W-1:0] csr_wr_data = '0;
   logic                           req_tvalid = 1'b0;
   wire                            req_tready;
   logic [cqs_pkg::DATA_W-1:0]     req_tdata = '0;
   logic [cqs_pkg::CMD_W-1:0]      req_tuser = '0;
   wire                            rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   wire [cqs_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   wire [cqs_pkg::STATUS_W-1:0]    rsp_tuser;

   // Shadow of the queue as the block should hold it.
   logic [cqs_pkg::DATA_W-1:0]     shadow_store [cqs_pkg::DEPTH_DEF];
   logic [cqs_pkg::FOUND_W-1:0]    shadow_head = '0;
   logic [cqs_pkg::FOUND_W-1:0]    shadow_tail = '0;
   logic [cqs_pkg::COUNT_W-1:0]    shadow_count = '0;
   logic [cqs_pkg::CAPACITY_W-1:0] shadow_capacity = cqs_pkg::CAPACITY_RESET;

   queue_cmd_type   commands_to_send [$];
   queue_reply_type replies_due [$];
   logic [cqs_pkg::DATA_W-1:0] value_pool [8];

   int total_queued = 0;
   int total_checked = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_pending = 1'b0;
   int hold_left = 0;

   circular_queue_with_search #(
      .DEPTH(cqs_pkg::DEPTH_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic logic [cqs_pkg::FOUND_W-1:0] next_slot(
         logic [cqs_pkg::FOUND_W-1:0] slot, logic [cqs_pkg::COUNT_W-1:0] wrap);
      return ({1'b0, slot} + 5'd1 >= wrap) ? '0 : slot + 4'd1;
   endfunction

   // Applies one command to the shadow queue and returns the reply it must produce.
   function automatic queue_reply_type apply_queue_command(
         logic [cqs_pkg::CMD_W-1:0] op, logic [cqs_pkg::DATA_W-1:0] value);
      queue_reply_type             reply;
      logic [cqs_pkg::COUNT_W-1:0] wrap;
      logic [cqs_pkg::FOUND_W-1:0] slot;
      int                          k;
      bit                          hit;
      reply = '0;
      hit = 1'b0;
      // Out-of-range capacities are clamped into 1..DEPTH.
      if (shadow_capacity == 0)
         wrap = 5'd1;
      else if (shadow_capacity > cqs_pkg::DEPTH_DEF)
         wrap = cqs_pkg::COUNT_W'(cqs_pkg::DEPTH_DEF);
      else
         wrap = shadow_capacity;
      reply.status = cqs_pkg::ST_OK;
      case (op)
         cqs_pkg::CMD_INSERT: begin
            if (shadow_count >= wrap) begin
               reply.status = cqs_pkg::ST_FULL;
            end else begin
               shadow_store[shadow_tail] = value;
               shadow_tail = next_slot(shadow_tail, wrap);
               shadow_count = shadow_count + 5'd1;
            end
         end
         cqs_pkg::CMD_REMOVE: begin
            if (shadow_count == 0) begin
               reply.status = cqs_pkg::ST_EMPTY;
            end else begin
               reply.removed = shadow_store[shadow_head];
               shadow_head = next_slot(shadow_head, wrap);
               shadow_count = shadow_count - 5'd1;
            end
         end
         cqs_pkg::CMD_SEARCH: begin
            if (shadow_count == 0) begin
               reply.status = cqs_pkg::ST_EMPTY;
            end else begin
               reply.status = cqs_pkg::ST_NOTFOUND;
               slot = shadow_head;
               for (k = 0; k < shadow_count && !hit; k++) begin
                  if (shadow_store[slot] == value) begin
                     hit = 1'b1;
                     reply.status = cqs_pkg::ST_OK;
                     reply.found = slot;
                  end else begin
                     slot = next_slot(slot, wrap);
                  end
               end
            end
         end
         default: ;
      endcase
      reply.count = shadow_count;
      reply.empty = (shadow_count == 0);
      reply.full = (shadow_count == wrap);
      return reply;
   endfunction

   function automatic void check_field(string name, logic [cqs_pkg::DATA_W-1:0] want,
                                       logic [cqs_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Mostly pool values so that searches hit and duplicates test first-match order.
   function automatic queue_cmd_type random_command(int insert_pct);
      queue_cmd_type cmd;
      int            roll;
      roll = $urandom_range(99);
      if (roll < 3)
         cmd.op = CMD_NOP;
      else if (roll < 3 + insert_pct)
         cmd.op = cqs_pkg::CMD_INSERT;
      else if ($urandom_range(1) == 0)
         cmd.op = cqs_pkg::CMD_REMOVE;
      else
         cmd.op = cqs_pkg::CMD_SEARCH;
      if ($urandom_range(99) < 65)
         cmd.value = value_pool[$urandom_range(7)];
      else
         cmd.value = $urandom;
      return cmd;
   endfunction

   task automatic queue_command(logic [cqs_pkg::CMD_W-1:0] op,
                                logic [cqs_pkg::DATA_W-1:0] value);
      queue_cmd_type cmd;
      cmd.op = op;
      cmd.value = value;
      commands_to_send.push_back(cmd);
      total_queued++;
   endtask

   task automatic wait_until_drained();
      while (total_checked < total_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A capacity write also empties the queue; storage is kept.
   task automatic write_capacity(logic [cqs_pkg::CAPACITY_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      shadow_capacity = value;
      shadow_head = '0;
      shadow_tail = '0;
      shadow_count = '0;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : driver
      queue_cmd_type next_cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_queue_command(req_tuser, req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (commands_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = commands_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_cmd.op;
               req_tdata <= next_cmd.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : holdoff
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : monitor
      queue_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            total_checked++;
            if (replies_due.size() == 0) begin
               $display("%0t: transfer with nothing expected, actual status %h data %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("removed_value", want.removed, rsp_tdata[31:0]);
               check_field("found_index", want.found, rsp_tdata[35:32]);
               check_field("entry_count", want.count, rsp_tdata[40:36]);
               check_field("is_empty", want.empty, rsp_tdata[41]);
               check_field("is_full", want.full, rsp_tdata[42]);
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : stimulus
      logic [cqs_pkg::CAPACITY_W-1:0] phase_caps [8];
      queue_cmd_type                  rnd_cmd;
      int                             p;
      int                             n;
      int                             insert_pct;
      for (n = 0; n < 8; n++) value_pool[n] = $urandom;
      phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd0};
      phase_caps[7] = cqs_pkg::CAPACITY_W'($urandom_range(31));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue first, then the extremes of the data word, at reset capacity.
      queue_command(cqs_pkg::CMD_REMOVE, 32'h0);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h0);
      queue_command(CMD_NOP, 32'hFFFF_FFFF);
      queue_command(cqs_pkg::CMD_INSERT, 32'h7FFF_FFFF);
      queue_command(cqs_pkg::CMD_INSERT, 32'h8000_0000);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0);
      queue_command(cqs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      queue_command(cqs_pkg::CMD_INSERT, 32'hAAAA_AAAA);
      queue_command(cqs_pkg::CMD_INSERT, 32'h5555_5555);
      queue_command(cqs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h1357_9BDF);
      queue_command(CMD_NOP, 32'h0);
      queue_command(cqs_pkg::CMD_REMOVE, 32'h0);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h8000_0000);
      wait_until_drained();

      // Single-entry ring: full on the second insert.
      write_capacity(5'd1);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_1234);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_5678);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h0000_1234);
      queue_command(cqs_pkg::CMD_REMOVE, 32'h0);
      queue_command(cqs_pkg::CMD_REMOVE, 32'h0);
      wait_until_drained();

      // Search across the wrap of the tail index.
      write_capacity(5'd3);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_000A);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_000B);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_000C);
      queue_command(cqs_pkg::CMD_REMOVE, 32'h0);
      queue_command(cqs_pkg::CMD_INSERT, 32'h0000_000D);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h0000_000D);
      queue_command(cqs_pkg::CMD_SEARCH, 32'h0000_000C);
      wait_until_drained();

      for (p = 0; p < 8; p++) begin
         write_capacity(phase_caps[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         insert_pct = 50;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Runs of fill-heavy and drain-heavy traffic reach full and empty.
            if (n % 32 == 0) begin
               case ($urandom_range(2))
                  0: insert_pct = 75;
                  1: insert_pct = 48;
                  default: insert_pct = 22;
               endcase
            end
            rnd_cmd = random_command(insert_pct);
            queue_command(rnd_cmd.op, rnd_cmd.value);
         end
         if (p == 0) hold_pending = 1'b1;
         wait_until_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
design/cqs_pkg.sv
design/cqs_ram.sv
design/cqs_ctrl.sv
design/cqs_datapath.sv
design/circular_queue_with_search.sv
verif/tb.sv
